// ===== src/rlhb_pkg.sv =====
// ----------------------------------------------------------------------------
// rlhb_pkg
// Shared types and constants for the RGB and luma histogram binner.
// ----------------------------------------------------------------------------
package rlhb_pkg;

    localparam int COUNT_BITS = 24;
    localparam int OUT_BITS   = 24;
    localparam int LEVELS     = 256;
    localparam int ADDR_BITS  = 8;
    localparam int N_HIST     = 4;

    localparam int HIST_RED   = 0;
    localparam int HIST_GREEN = 1;
    localparam int HIST_BLUE  = 2;
    localparam int HIST_LUMA  = 3;

    localparam int PROD_BITS = 24;

    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    localparam int CFG_DATA_BITS = 9;

    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_BIN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        CFG_BIN_COUNT = 1'b0,
        CFG_GRAY_TOL  = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_A,
        ST_PIX_B,
        ST_PIX_C,
        ST_READ_A,
        ST_READ_B,
        ST_DIV,
        ST_BIN_RD,
        ST_BIN_LAST,
        ST_BIN_WR
    } t_state;

endpackage

// ===== src/rlhb_ram.sv =====
// ----------------------------------------------------------------------------
// rlhb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rlhb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rlhb_pixel.sv =====
// ----------------------------------------------------------------------------
// rlhb_pixel
// Two-stage pixel unit: weighted luma products, then sum; grayscale check.
// ----------------------------------------------------------------------------
module rlhb_pixel
    import rlhb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_tol,
    output logic [7:0] o_luma,
    output logic       o_off
);

    logic [PROD_BITS-1:0] r_p_red;
    logic [PROD_BITS-1:0] r_p_green;
    logic [PROD_BITS-1:0] r_p_blue;
    logic                 r_off1;
    logic [7:0]           r_luma;
    logic                 r_off;
    logic [7:0]           d_rg;
    logic [7:0]           d_rb;
    logic [7:0]           d_gb;
    logic                 n_off1;
    logic [PROD_BITS-1:0] sum;

    always_comb begin
        d_rg   = (i_red > i_green) ? i_red - i_green : i_green - i_red;
        d_rb   = (i_red > i_blue) ? i_red - i_blue : i_blue - i_red;
        d_gb   = (i_green > i_blue) ? i_green - i_blue : i_blue - i_green;
        n_off1 = !((d_rg < i_tol) && (d_rb < i_tol) && (d_gb < i_tol));
        sum    = r_p_red + r_p_green + r_p_blue;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_red   <= PROD_BITS'(W_RED) * PROD_BITS'(i_red);
            r_p_green <= PROD_BITS'(W_GREEN) * PROD_BITS'(i_green);
            r_p_blue  <= PROD_BITS'(W_BLUE) * PROD_BITS'(i_blue);
            r_off1    <= n_off1;
        end
        r_luma <= sum[PROD_BITS-1 -: 8];
        r_off  <= r_off1;
    end

    assign o_luma = r_luma;
    assign o_off  = r_off;

endmodule

// ===== src/rgb_luma_histogram_binner_top.sv =====
// ----------------------------------------------------------------------------
// rgb_luma_histogram_binner_top
// Red, green, blue and luma histograms with saturating counts, grayscale
// flag, bin pass, entry read and clear.
//
// Usage:
//   A request is taken when i_start is high and o_busy is low. i_action picks
//   pixel, bin pass, read entry or clear. Each request gives one result,
//   shown for one cycle with o_done high; the receiver cannot stall it.
//   Requests are handled one at a time; the four histogram memories do one
//   read and one write per cycle, which sets the pass lengths.
//   After reset the block sweeps all 256 entries to zero with o_busy high
//   before it takes a request. Registers are written through
//   i_cfg_we / i_cfg_index / i_cfg_data outside reset, while idle in practice.
// ----------------------------------------------------------------------------
module rgb_luma_histogram_binner_top
    import rlhb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_start,
    input  logic [1:0]               i_action,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    input  logic [7:0]               i_entry_index,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [7:0]               o_luma,
    output logic                     o_all_gray,
    output logic [OUT_BITS-1:0]      o_red_count,
    output logic [OUT_BITS-1:0]      o_green_count,
    output logic [OUT_BITS-1:0]      o_blue_count,
    output logic [OUT_BITS-1:0]      o_luma_count
);

    localparam logic [8:0] DIVIDEND = 9'(LEVELS);

    t_state          r_state, n_state;
    logic            r_gray, n_gray;
    logic [8:0]      r_bin_count;
    logic [7:0]      r_tol;
    logic            r_done, n_done;
    logic            r_clr_emit, n_clr_emit;

    logic [7:0]      r_red, r_green, r_blue, r_idx;
    logic [7:0]      n_red, n_green, n_blue, n_idx;
    logic [8:0]      r_pos, n_pos;
    logic [8:0]      r_start, n_start;
    logic [8:0]      r_end, n_end;
    logic [8:0]      r_width, n_width;
    logic [8:0]      r_rem, n_rem;
    logic [8:0]      r_quo, n_quo;
    logic [3:0]      r_dcnt, n_dcnt;
    logic            r_pend, n_pend;
    t_count          r_sum [N_HIST];
    t_count          n_sum [N_HIST];
    logic [7:0]      r_out_luma, n_out_luma;
    logic [OUT_BITS-1:0] r_out_cnt [N_HIST];
    logic [OUT_BITS-1:0] n_out_cnt [N_HIST];

    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr [N_HIST];
    t_count               ram_wdata [N_HIST];
    logic [ADDR_BITS-1:0] ram_raddr [N_HIST];
    t_count               ram_rdata [N_HIST];
    logic [ADDR_BITS-1:0] pix_addr [N_HIST];

    logic                 accept;
    logic [7:0]           pix_luma;
    logic                 pix_off;
    logic [9:0]           trial;
    logic [COUNT_BITS:0]  acc [N_HIST];
    t_count               acc_sat [N_HIST];
    logic [9:0]           next_end;

    assign accept = i_start && (r_state == ST_IDLE);

    rlhb_pixel u_pixel (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_tol   (r_tol),
        .o_luma  (pix_luma),
        .o_off   (pix_off)
    );

    for (genvar h = 0; h < N_HIST; h++) begin : g_hist
        rlhb_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (LEVELS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (ram_waddr[h]),
            .i_wdata (ram_wdata[h]),
            .i_raddr (ram_raddr[h]),
            .o_rdata (ram_rdata[h])
        );
    end

    always_comb begin
        pix_addr[HIST_RED]   = r_red;
        pix_addr[HIST_GREEN] = r_green;
        pix_addr[HIST_BLUE]  = r_blue;
        pix_addr[HIST_LUMA]  = pix_luma;
        for (int h = 0; h < N_HIST; h++) begin
            acc[h]     = {1'b0, r_sum[h]} + {1'b0, ram_rdata[h]};
            acc_sat[h] = acc[h][COUNT_BITS] ? COUNT_MAX : acc[h][COUNT_BITS-1:0];
        end
        trial    = {r_rem, DIVIDEND[r_dcnt]};
        next_end = {1'b0, r_end} + {1'b0, r_width};
    end

    always_comb begin
        n_state    = r_state;
        n_gray     = r_gray;
        n_done     = 1'b0;
        n_clr_emit = r_clr_emit;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_start    = r_start;
        n_end      = r_end;
        n_width    = r_width;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dcnt     = r_dcnt;
        n_pend     = 1'b0;
        n_out_luma = r_out_luma;
        ram_we     = 1'b0;
        for (int h = 0; h < N_HIST; h++) begin
            n_sum[h]     = r_sum[h];
            n_out_cnt[h] = r_out_cnt[h];
            ram_waddr[h] = r_pos[ADDR_BITS-1:0];
            ram_wdata[h] = '0;
            ram_raddr[h] = r_pos[ADDR_BITS-1:0];
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_pos  = r_pos + 9'd1;
                if (r_pos == 9'(LEVELS - 1)) begin
                    n_gray  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_clr_emit) begin
                        n_done     = 1'b1;
                        n_out_luma = '0;
                        for (int h = 0; h < N_HIST; h++) begin
                            n_out_cnt[h] = '0;
                        end
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_red   = i_red;
                    n_green = i_green;
                    n_blue  = i_blue;
                    n_idx   = i_entry_index;
                    unique case (t_action'(i_action))
                        ACT_PIXEL: n_state = ST_PIX_A;
                        ACT_BIN: begin
                            n_rem   = '0;
                            n_quo   = '0;
                            n_dcnt  = 4'd8;
                            n_state = ST_DIV;
                        end
                        ACT_READ: n_state = ST_READ_A;
                        ACT_CLEAR: begin
                            n_pos      = '0;
                            n_clr_emit = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_A: n_state = ST_PIX_B;
            ST_PIX_B: begin
                for (int h = 0; h < N_HIST; h++) begin
                    ram_raddr[h] = pix_addr[h];
                end
                n_state = ST_PIX_C;
            end
            ST_PIX_C: begin
                ram_we = 1'b1;
                for (int h = 0; h < N_HIST; h++) begin
                    ram_waddr[h] = pix_addr[h];
                    ram_wdata[h] = (ram_rdata[h] == COUNT_MAX) ? COUNT_MAX
                                                              : ram_rdata[h] + 1'b1;
                    n_out_cnt[h] = '0;
                end
                if (pix_off) begin
                    n_gray = 1'b0;
                end
                n_done     = 1'b1;
                n_out_luma = pix_luma;
                n_state    = ST_IDLE;
            end
            ST_READ_A: begin
                for (int h = 0; h < N_HIST; h++) begin
                    ram_raddr[h] = r_idx;
                end
                n_state = ST_READ_B;
            end
            ST_READ_B: begin
                for (int h = 0; h < N_HIST; h++) begin
                    n_out_cnt[h] = OUT_BITS'(ram_rdata[h]);
                end
                n_done     = 1'b1;
                n_out_luma = '0;
                n_state    = ST_IDLE;
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_bin_count}) begin
                    n_rem = 9'(trial - {1'b0, r_bin_count});
                    n_quo = {r_quo[7:0], 1'b1};
                end else begin
                    n_rem = trial[8:0];
                    n_quo = {r_quo[7:0], 1'b0};
                end
                n_dcnt = r_dcnt - 4'd1;
                if (r_dcnt == 4'd0) begin
                    n_width = (r_bin_count == 9'd0) ? 9'd0 : n_quo;
                    if (n_width == 9'd0) begin
                        n_done     = 1'b1;
                        n_out_luma = '0;
                        for (int h = 0; h < N_HIST; h++) begin
                            n_out_cnt[h] = '0;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_start = '0;
                        n_pos   = '0;
                        n_end   = n_width;
                        for (int h = 0; h < N_HIST; h++) begin
                            n_sum[h] = '0;
                        end
                        n_state = ST_BIN_RD;
                    end
                end
            end
            ST_BIN_RD: begin
                n_pend = 1'b1;
                if (r_pend) begin
                    for (int h = 0; h < N_HIST; h++) begin
                        n_sum[h] = acc_sat[h];
                    end
                end
                if (r_pos + 9'd1 == r_end) begin
                    n_pos   = r_start;
                    n_state = ST_BIN_LAST;
                end else begin
                    n_pos = r_pos + 9'd1;
                end
            end
            ST_BIN_LAST: begin
                for (int h = 0; h < N_HIST; h++) begin
                    n_sum[h] = acc_sat[h];
                end
                n_state = ST_BIN_WR;
            end
            ST_BIN_WR: begin
                ram_we = 1'b1;
                for (int h = 0; h < N_HIST; h++) begin
                    ram_wdata[h] = r_sum[h];
                end
                n_pos = r_pos + 9'd1;
                if (r_pos + 9'd1 == r_end) begin
                    if (next_end <= 10'(LEVELS)) begin
                        n_start = r_end;
                        n_pos   = r_end;
                        n_end   = next_end[8:0];
                        for (int h = 0; h < N_HIST; h++) begin
                            n_sum[h] = '0;
                        end
                        n_state = ST_BIN_RD;
                    end else begin
                        n_done     = 1'b1;
                        n_out_luma = '0;
                        for (int h = 0; h < N_HIST; h++) begin
                            n_out_cnt[h] = '0;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_gray      <= 1'b1;
            r_done      <= 1'b0;
            r_clr_emit  <= 1'b0;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_bin_count <= 9'd256;
            r_tol       <= 8'd10;
        end else begin
            r_state    <= n_state;
            r_gray     <= n_gray;
            r_done     <= n_done;
            r_clr_emit <= n_clr_emit;
            r_pos      <= n_pos;
            r_pend     <= n_pend;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_BIN_COUNT: r_bin_count <= i_cfg_data[8:0];
                    CFG_GRAY_TOL:  r_tol       <= i_cfg_data[7:0];
                    default:       r_tol       <= r_tol;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_idx      <= n_idx;
        r_start    <= n_start;
        r_end      <= n_end;
        r_width    <= n_width;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dcnt     <= n_dcnt;
        r_out_luma <= n_out_luma;
        for (int h = 0; h < N_HIST; h++) begin
            r_sum[h]     <= n_sum[h];
            r_out_cnt[h] <= n_out_cnt[h];
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_luma        = r_out_luma;
    assign o_all_gray    = r_gray;
    assign o_red_count   = r_out_cnt[HIST_RED];
    assign o_green_count = r_out_cnt[HIST_GREEN];
    assign o_blue_count  = r_out_cnt[HIST_BLUE];
    assign o_luma_count  = r_out_cnt[HIST_LUMA];

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB and luma histogram binner. A tracker
// class keeps its own copy of the four histograms, the grayscale flag and
// both registers, and predicts every result as each request is taken.
// Directed requests cover the field extremes and the tolerance edges. They
// also cover counts pushed into saturation by repeated single-bin passes,
// and passes with a zero or oversized bin count. Random phases then run
// under several register settings, with bursty request timing.
// ----------------------------------------------------------------------------
module testbench
    import rlhb_pkg::*;
();

    localparam int unsigned RED_WEIGHT   = 13933;
    localparam int unsigned GREEN_WEIGHT = 46871;
    localparam int unsigned BLUE_WEIGHT  = 4732;
    localparam int RUN_LIMIT   = 4000000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int BIN_PLAN [PHASES] = '{256, 1, 3, 0, 128, 300, 7, 2, 64, 511};
    localparam int TOL_PLAN [PHASES] = '{10, 0, 255, 20, 5, 1, 40, 128, 3, 10};

    typedef struct packed {
        logic [7:0]          luma;
        logic                all_gray;
        logic [OUT_BITS-1:0] red_count;
        logic [OUT_BITS-1:0] green_count;
        logic [OUT_BITS-1:0] blue_count;
        logic [OUT_BITS-1:0] luma_count;
    } t_readout;

    class histogram_tracker;
        t_count     hist [N_HIST][LEVELS];
        logic       gray_so_far;
        logic [8:0] bin_cnt;
        logic [7:0] gray_tol;
        t_readout   pending_readouts [$];
        int         errors;

        function new();
            clear_store();
            bin_cnt  = 9'd256;
            gray_tol = 8'd10;
            errors   = 0;
        endfunction

        function void clear_store();
            for (int h = 0; h < N_HIST; h++)
                for (int e = 0; e < LEVELS; e++)
                    hist[h][e] = '0;
            gray_so_far = 1'b1;
        endfunction

        function void write_reg(t_cfg_index idx, logic [8:0] data);
            if (idx == CFG_BIN_COUNT)
                bin_cnt = data;
            else
                gray_tol = data[7:0];
        endfunction

        function int spread(logic [7:0] a, logic [7:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        function void bump(int h, logic [7:0] e);
            if (hist[h][e] != COUNT_MAX)
                hist[h][e] = hist[h][e] + 1'b1;
        endfunction

        function void merge_bins(int width);
            longint unsigned total;
            for (int h = 0; h < N_HIST; h++) begin
                for (int first = 0; first + width <= LEVELS; first += width) begin
                    total = 0;
                    for (int j = first; j < first + width; j++) begin
                        total += hist[h][j];
                        if (total > COUNT_MAX)
                            total = COUNT_MAX;
                    end
                    for (int j = first; j < first + width; j++)
                        hist[h][j] = t_count'(total);
                end
            end
        endfunction

        function void take_request(t_action act, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic [7:0] e);
            t_readout    want;
            int unsigned weighted;
            int          width;
            want = '0;
            case (act)
                ACT_PIXEL: begin
                    weighted = RED_WEIGHT * r + GREEN_WEIGHT * g + BLUE_WEIGHT * b;
                    want.luma = weighted[23:16];
                    if (!(spread(r, g) < gray_tol && spread(r, b) < gray_tol &&
                          spread(g, b) < gray_tol))
                        gray_so_far = 1'b0;
                    bump(HIST_RED, r);
                    bump(HIST_GREEN, g);
                    bump(HIST_BLUE, b);
                    bump(HIST_LUMA, want.luma);
                end
                ACT_BIN: begin
                    width = (bin_cnt == 0) ? 0 : LEVELS / int'(bin_cnt);
                    if (width != 0)
                        merge_bins(width);
                end
                ACT_READ: begin
                    want.red_count   = hist[HIST_RED][e];
                    want.green_count = hist[HIST_GREEN][e];
                    want.blue_count  = hist[HIST_BLUE][e];
                    want.luma_count  = hist[HIST_LUMA][e];
                end
                default: begin
                    clear_store();
                end
            endcase
            want.all_gray = gray_so_far;
            pending_readouts.push_back(want);
        endfunction

        function void compare_readout(t_readout got);
            t_readout want;
            if (pending_readouts.size() == 0) begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            want = pending_readouts.pop_front();
            if (got.luma !== want.luma) begin
                $error("luma: expected %0d, actual %0d", want.luma, got.luma);
                errors++;
            end
            if (got.all_gray !== want.all_gray) begin
                $error("all_gray: expected %0d, actual %0d", want.all_gray, got.all_gray);
                errors++;
            end
            if (got.red_count !== want.red_count) begin
                $error("red_count: expected %0d, actual %0d", want.red_count, got.red_count);
                errors++;
            end
            if (got.green_count !== want.green_count) begin
                $error("green_count: expected %0d, actual %0d",
                       want.green_count, got.green_count);
                errors++;
            end
            if (got.blue_count !== want.blue_count) begin
                $error("blue_count: expected %0d, actual %0d",
                       want.blue_count, got.blue_count);
                errors++;
            end
            if (got.luma_count !== want.luma_count) begin
                $error("luma_count: expected %0d, actual %0d",
                       want.luma_count, got.luma_count);
                errors++;
            end
        endfunction

        function int pending();
            return pending_readouts.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [8:0]          i_cfg_data;
    logic                i_start;
    logic [1:0]          i_action;
    logic [7:0]          i_red;
    logic [7:0]          i_green;
    logic [7:0]          i_blue;
    logic [7:0]          i_entry_index;
    logic                o_busy;
    logic                o_done;
    logic [7:0]          o_luma;
    logic                o_all_gray;
    logic [OUT_BITS-1:0] o_red_count;
    logic [OUT_BITS-1:0] o_green_count;
    logic [OUT_BITS-1:0] o_blue_count;
    logic [OUT_BITS-1:0] o_luma_count;

    histogram_tracker tracker;
    int               cycles = 0;
    logic [7:0]       last_red;
    logic [7:0]       last_green;
    logic [7:0]       last_blue;

    rgb_luma_histogram_binner_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .i_action      (i_action),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_entry_index (i_entry_index),
        .o_busy        (o_busy),
        .o_done        (o_done),
        .o_luma        (o_luma),
        .o_all_gray    (o_all_gray),
        .o_red_count   (o_red_count),
        .o_green_count (o_green_count),
        .o_blue_count  (o_blue_count),
        .o_luma_count  (o_luma_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            tracker.compare_readout(t_readout'{
                luma:        o_luma,
                all_gray:    o_all_gray,
                red_count:   o_red_count,
                green_count: o_green_count,
                blue_count:  o_blue_count,
                luma_count:  o_luma_count
            });
    end

    task automatic send_request(t_action act, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic [7:0] e);
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_action      <= act;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_entry_index <= e;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        tracker.take_request(act, r, g, b, e);
        if (act == ACT_PIXEL) begin
            last_red   = r;
            last_green = g;
            last_blue  = b;
        end
    endtask

    task automatic hold_idle(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (tracker.pending() != 0 || o_busy !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [8:0] data);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    function automatic void pick_pixel(output logic [7:0] r, output logic [7:0] g,
                                       output logic [7:0] b);
        int reach;
        int base;
        if ($urandom_range(0, 1) == 0) begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end else begin
            reach = $urandom_range(0, tracker.gray_tol);
            base  = $urandom_range(0, 255 - reach);
            r = 8'(base + $urandom_range(0, reach));
            g = 8'(base + $urandom_range(0, reach));
            b = 8'(base + $urandom_range(0, reach));
        end
    endfunction

    initial begin
        int         burst_left;
        int         roll;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] e;
        t_action    act;

        tracker       = new();
        burst_left    = 0;
        last_red      = 8'd0;
        last_green    = 8'd0;
        last_blue     = 8'd0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BIN_COUNT;
        i_cfg_data    = '0;
        i_start       = 1'b0;
        i_action      = ACT_PIXEL;
        i_red         = '0;
        i_green       = '0;
        i_blue        = '0;
        i_entry_index = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_BIN_COUNT, 9'd256);
        write_reg(CFG_GRAY_TOL, 9'd10);
        send_request(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(ACT_PIXEL, 8'd100, 8'd109, 8'd105, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(ACT_PIXEL, 8'd100, 8'd110, 8'd100, 8'd0);
        send_request(ACT_PIXEL, 8'd255, 8'd0, 8'd128, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd100);
        send_request(ACT_BIN, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        send_request(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0);

        // single bin: each pass multiplies the total by 256 until it saturates
        write_reg(CFG_BIN_COUNT, 9'd1);
        write_reg(CFG_GRAY_TOL, 9'd0);
        send_request(ACT_PIXEL, 8'd7, 8'd7, 8'd7, 8'd0);
        send_request(ACT_PIXEL, 8'd200, 8'd201, 8'd199, 8'd0);
        repeat (4) send_request(ACT_BIN, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_PIXEL, 8'd7, 8'd7, 8'd7, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd7);

        write_reg(CFG_BIN_COUNT, 9'd0);
        send_request(ACT_BIN, 8'd0, 8'd0, 8'd0, 8'd0);
        write_reg(CFG_BIN_COUNT, 9'd511);
        send_request(ACT_BIN, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd7);

        write_reg(CFG_BIN_COUNT, 9'd3);
        write_reg(CFG_GRAY_TOL, 9'd255);
        send_request(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_PIXEL, 8'd0, 8'd254, 8'd0, 8'd0);
        send_request(ACT_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0);
        send_request(ACT_BIN, 8'd0, 8'd0, 8'd0, 8'd0);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        send_request(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_reg(CFG_BIN_COUNT, 9'(BIN_PLAN[phase]));
            write_reg(CFG_GRAY_TOL, 9'(TOL_PLAN[phase]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    if (phase != 0 && $urandom_range(0, 2) != 0)
                        hold_idle($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6));
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                r    = 8'($urandom);
                g    = 8'($urandom);
                b    = 8'($urandom);
                e    = 8'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    act = ACT_PIXEL;
                    pick_pixel(r, g, b);
                end else if (roll < 88) begin
                    act = ACT_READ;
                    case ($urandom_range(0, 3))
                        0: e = last_red;
                        1: e = last_green;
                        2: e = last_blue;
                        default: e = e;
                    endcase
                end else if (roll < 94) begin
                    act = ACT_BIN;
                end else begin
                    act = ACT_CLEAR;
                end
                send_request(act, r, g, b, e);
            end
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
